// ===== hw/rtl/mmat_pkg.sv =====
`default_nettype none
package mmat_pkg;

  typedef struct packed {
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic               last_point;
  } in_t;

  typedef struct packed {
    logic [4:0] corner_first;
    logic [4:0] corner_apex;
    logic [4:0] corner_second;
    logic       last_triangle;
    logic [1:0] status;
  } out_t;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_PEN  = 2'd1;
  localparam logic [1:0] STAT_FEW  = 2'd2;
  localparam logic [1:0] STAT_MANY = 2'd3;

  localparam int          CORDIC_STEPS = 31;
  localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;

  typedef enum logic [4:0] {
    S_IDLE, S_FI, S_FJ, S_FK, S_CK, S_CJ, S_AREA, S_MUL0, S_MUL1, S_POST,
    S_DOT_SET, S_CINIT, S_CITER, S_CDONE, S_OFETCH, S_OWAIT, S_IN_SET,
    S_SUM, S_WRITE, S_BINIT, S_QRD, S_QWAIT, S_SWAIT, S_PUSH1, S_PUSH2
  } state_t;

  typedef enum logic [1:0] {
    PH_AREA, PH_DOT, PH_IN
  } phase_t;

  function automatic logic [30:0] atan_q30(input logic [4:0] s);
    logic [30:0] v;
    case (s)
      5'd0:  v = 31'd843314857;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043837;
      5'd3:  v = 31'd133525159;
      5'd4:  v = 31'd67021687;
      5'd5:  v = 31'd33543516;
      5'd6:  v = 31'd16775851;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194283;
      5'd9:  v = 31'd2097149;
      default: v = 31'd1 << (5'd30 - s);
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/min_max_angle_polygon_triangulation.sv =====
`default_nettype none
// vertex load: one vertex per cycle while idle; an error result follows in the cycle after the last vertex
// triangulation: run time is set by the single shared 2-input multiplier and the
// one-step-per-cycle cordic; each result passes states qrd, qwait, swait, push1, push2
// busy is high from the last vertex of a valid polygon until the split queue runs empty; no stalls
// synchronous active-low reset clears control state; point, cost and split stores are not cleared
module min_max_angle_polygon_triangulation #(
  parameter int MAX_POINTS      = 32,
  parameter int COORD_BITS      = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire mmat_pkg::in_t in_data,
  output logic              out_valid,
  output mmat_pkg::out_t    out_data
);
  import mmat_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int AW = PW + 1;
  localparam int KW = AW + 3;
  localparam int ZW = 34;
  localparam logic [31:0]   PENALTY = 32'(1024) << ANGLE_FRAC_BITS;
  localparam logic [ZW:0]   RND     = (ZW + 1)'(1) << (29 - ANGLE_FRAC_BITS);
  localparam logic [CW-1:0] MAXC    = CW'(MAX_POINTS);

  typedef logic signed [COORD_BITS-1:0] crd_t;

  // memories
  logic [COORD_BITS-1:0] ptx_mem [MAX_POINTS];
  logic [COORD_BITS-1:0] pty_mem [MAX_POINTS];
  logic [31:0]           cost_mem [2**(2*IW)];
  logic [IW-1:0]         split_mem [2**(2*IW)];
  logic [2*IW-1:0]       q_mem [MAX_POINTS];

  logic                  pt_we;
  logic [IW-1:0]         pt_addr;
  crd_t                  pt_rdx_r, pt_rdy_r;
  logic [2*IW-1:0]       tab_raddr, tab_waddr;
  logic                  tab_we;
  logic [31:0]           cost_rd_r;
  logic [IW-1:0]         split_rd_r;
  logic                  q_we;
  logic [IW-1:0]         q_waddr;
  logic [2*IW-1:0]       q_wdata;
  logic [2*IW-1:0]       q_rd_r;
  crd_t                  in_x, in_y;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt, n_r, n_nxt, size_r, size_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, o_r, o_nxt;
  logic [CW-1:0] head_r, head_nxt, tail_r, tail_nxt, res_r, res_nxt;
  logic [CW-1:0] qi_r, qi_nxt, qj_r, qj_nxt, qk_r, qk_nxt, bk_r, bk_nxt;
  logic          ovf_r, ovf_nxt;
  crd_t          pix_r, piy_r, pjx_r, pjy_r, pkx_r, pky_r, pox_r, poy_r;
  crd_t          pix_nxt, piy_nxt, pjx_nxt, pjy_nxt, pkx_nxt, pky_nxt, pox_nxt, poy_nxt;
  logic [31:0]   cik_r, cik_nxt, ckj_r, ckj_nxt, best_r, best_nxt;
  logic [31:0]   tri_r, tri_nxt, m_r, m_nxt;
  logic signed [AW-1:0] area_r, area_nxt, acc_r, acc_nxt;
  logic signed [DW-1:0] ux_r, uy_r, vx_r, vy_r, ux_nxt, uy_nxt, vx_nxt, vy_nxt;
  logic          dot_r, dot_nxt;
  logic [1:0]    cv_r, cv_nxt, ci_r, ci_nxt;
  logic signed [KW-1:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic signed [ZW-1:0] cz_r, cz_nxt;
  logic [4:0]    s_r, s_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic          ov_r, ov_nxt;
  out_t          od_r, od_nxt;

  // shared multiplier
  logic signed [DW-1:0] ma, mb;
  logic signed [PW-1:0] mul_p;
  assign mul_p = PW'(ma) * PW'(mb);

  assign in_x = COORD_BITS'({{16{in_data.x_coord[15]}}, in_data.x_coord});
  assign in_y = COORD_BITS'({{16{in_data.y_coord[15]}}, in_data.y_coord});

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (pt_we) begin
      ptx_mem[cnt_r[IW-1:0]] <= in_x;
      pty_mem[cnt_r[IW-1:0]] <= in_y;
    end
    pt_rdx_r <= ptx_mem[pt_addr];
    pt_rdy_r <= pty_mem[pt_addr];
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      cost_mem[tab_waddr]  <= best_r;
      split_mem[tab_waddr] <= bk_r[IW-1:0];
    end
    cost_rd_r  <= cost_mem[tab_raddr];
    split_rd_r <= split_mem[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rd_r <= q_mem[head_r[IW-1:0]];
  end

  // next state
  logic [CW:0]  nn;
  logic         ovf_any;
  logic [33:0]  sum_v;
  logic [31:0]  val;
  logic [ZW-1:0] zc;
  logic [ZW:0]  zsum;
  logic [31:0]  ang;

  always_comb begin
    nn      = (cnt_r < MAXC) ? ({1'b0, cnt_r} + 1'b1) : {1'b0, cnt_r};
    ovf_any = ovf_r || (cnt_r == MAXC);
    sum_v   = 34'(cik_r) + 34'(ckj_r) + 34'(tri_r);
    val     = (sum_v > 34'h0FFFFFFFF) ? 32'hFFFFFFFF : sum_v[31:0];
    zc      = cz_r[ZW-1] ? '0 : cz_r;
    zsum    = {1'b0, zc} + RND;
    ang     = 32'(zsum >> (30 - ANGLE_FRAC_BITS));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start && in_data.last_point && !ovf_any && nn >= (CW + 1)'(3)) begin
          state_nxt = S_FI;
        end
      end
      S_FI:      state_nxt = S_FJ;
      S_FJ:      state_nxt = S_FK;
      S_FK:      state_nxt = S_CK;
      S_CK:      state_nxt = S_CJ;
      S_CJ:      state_nxt = S_AREA;
      S_AREA:    state_nxt = S_MUL0;
      S_MUL0:    state_nxt = S_MUL1;
      S_MUL1:    state_nxt = S_POST;
      S_POST: begin
        unique case (phase_r)
          PH_AREA: state_nxt = (acc_r > 0) ? S_DOT_SET : S_SUM;
          PH_DOT:  state_nxt = S_CINIT;
          PH_IN: begin
            if (acc_r <= 0) state_nxt = S_OFETCH;
            else if (ci_r == 2'd2) state_nxt = S_SUM;
            else state_nxt = S_IN_SET;
          end
          default: state_nxt = S_SUM;
        endcase
      end
      S_DOT_SET: state_nxt = S_MUL0;
      S_CINIT:   state_nxt = S_CITER;
      S_CITER:   state_nxt = (s_r == 5'(CORDIC_STEPS - 1)) ? S_CDONE : S_CITER;
      S_CDONE:   state_nxt = (cv_r == 2'd2) ? S_OFETCH : S_DOT_SET;
      S_OFETCH: begin
        if (o_r == n_r) state_nxt = S_SUM;
        else if (o_r != i_r && o_r != j_r && o_r != k_r) state_nxt = S_OWAIT;
      end
      S_OWAIT:   state_nxt = S_IN_SET;
      S_IN_SET:  state_nxt = S_MUL0;
      S_SUM:     state_nxt = ((k_r + 1'b1) == j_r) ? S_WRITE : S_FK;
      S_WRITE:   state_nxt = ((size_r + 1'b1) == n_r) ? S_BINIT : S_FI;
      S_BINIT:   state_nxt = S_QRD;
      S_QRD:     state_nxt = (head_r == tail_r) ? S_IDLE : S_QWAIT;
      S_QWAIT:   state_nxt = S_SWAIT;
      S_SWAIT:   state_nxt = S_PUSH1;
      S_PUSH1:   state_nxt = S_PUSH2;
      S_PUSH2:   state_nxt = S_QRD;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  crd_t ax, ay, bx, by, cxp, cyp;
  logic [CW:0] last_cmp;

  always_comb begin
    cnt_nxt = cnt_r;  n_nxt = n_r;  size_nxt = size_r;  ovf_nxt = ovf_r;
    i_nxt = i_r;  j_nxt = j_r;  k_nxt = k_r;  o_nxt = o_r;
    head_nxt = head_r;  tail_nxt = tail_r;  res_nxt = res_r;
    qi_nxt = qi_r;  qj_nxt = qj_r;  qk_nxt = qk_r;  bk_nxt = bk_r;
    pix_nxt = pix_r;  piy_nxt = piy_r;  pjx_nxt = pjx_r;  pjy_nxt = pjy_r;
    pkx_nxt = pkx_r;  pky_nxt = pky_r;  pox_nxt = pox_r;  poy_nxt = poy_r;
    cik_nxt = cik_r;  ckj_nxt = ckj_r;  best_nxt = best_r;  tri_nxt = tri_r;
    m_nxt = m_r;  area_nxt = area_r;  acc_nxt = acc_r;
    ux_nxt = ux_r;  uy_nxt = uy_r;  vx_nxt = vx_r;  vy_nxt = vy_r;
    dot_nxt = dot_r;  phase_nxt = phase_r;  cv_nxt = cv_r;  ci_nxt = ci_r;
    cx_nxt = cx_r;  cy_nxt = cy_r;  cz_nxt = cz_r;  s_nxt = s_r;
    stat_nxt = stat_r;
    ov_nxt = 1'b0;  od_nxt = od_r;
    pt_we = 1'b0;  pt_addr = i_r[IW-1:0];
    tab_we = 1'b0;  tab_raddr = {i_r[IW-1:0], k_r[IW-1:0]};
    tab_waddr = {i_r[IW-1:0], j_r[IW-1:0]};
    q_we = 1'b0;  q_waddr = tail_r[IW-1:0];  q_wdata = '0;
    ma = ux_r;  mb = vy_r;
    ax = pix_r;  ay = piy_r;  bx = pkx_r;  by = pky_r;  cxp = pjx_r;  cyp = pjy_r;
    last_cmp = {1'b0, res_r} + 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          pt_we = (cnt_r < MAXC);
          if (!in_data.last_point) begin
            if (cnt_r < MAXC) cnt_nxt = cnt_r + 1'b1;
            else ovf_nxt = 1'b1;
          end else begin
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
            if (ovf_any || nn < (CW + 1)'(3)) begin
              ov_nxt = 1'b1;
              od_nxt = '{corner_first: '0, corner_apex: '0, corner_second: '0,
                         last_triangle: 1'b1, status: ovf_any ? STAT_MANY : STAT_FEW};
            end else begin
              n_nxt    = CW'(nn);
              size_nxt = CW'(2);
              i_nxt    = '0;
              j_nxt    = CW'(2);
            end
          end
        end
      end
      S_FI: begin
        pt_addr = i_r[IW-1:0];
        k_nxt   = i_r + 1'b1;
      end
      S_FJ: begin
        pt_addr = j_r[IW-1:0];
        pix_nxt = pt_rdx_r;
        piy_nxt = pt_rdy_r;
      end
      S_FK: begin
        pt_addr = k_r[IW-1:0];
        // first pass follows the fetch of j
        if (k_r == i_r + 1'b1) begin
          pjx_nxt = pt_rdx_r;
          pjy_nxt = pt_rdy_r;
        end
      end
      S_CK: begin
        pkx_nxt   = pt_rdx_r;
        pky_nxt   = pt_rdy_r;
        tab_raddr = {i_r[IW-1:0], k_r[IW-1:0]};
      end
      S_CJ: begin
        cik_nxt   = (k_r == i_r + 1'b1) ? '0 : cost_rd_r;
        tab_raddr = {k_r[IW-1:0], j_r[IW-1:0]};
      end
      S_AREA: begin
        ckj_nxt   = (j_r == k_r + 1'b1) ? '0 : cost_rd_r;
        ux_nxt    = DW'(pkx_r) - DW'(pix_r);
        uy_nxt    = DW'(pky_r) - DW'(piy_r);
        vx_nxt    = DW'(pjx_r) - DW'(pix_r);
        vy_nxt    = DW'(pjy_r) - DW'(piy_r);
        dot_nxt   = 1'b0;
        phase_nxt = PH_AREA;
        m_nxt     = '0;
      end
      S_MUL0: begin
        ma      = ux_r;
        mb      = dot_r ? vx_r : vy_r;
        acc_nxt = AW'(mul_p);
      end
      S_MUL1: begin
        ma      = uy_r;
        mb      = dot_r ? vy_r : vx_r;
        acc_nxt = dot_r ? (acc_r + AW'(mul_p)) : (acc_r - AW'(mul_p));
      end
      S_POST: begin
        unique case (phase_r)
          PH_AREA: begin
            area_nxt = acc_r;
            cv_nxt   = '0;
            if (acc_r <= 0) tri_nxt = PENALTY;
          end
          PH_IN: begin
            if (acc_r <= 0) o_nxt = o_r + 1'b1;
            else if (ci_r == 2'd2) tri_nxt = PENALTY;
            else ci_nxt = ci_r + 1'b1;
          end
          default: ;
        endcase
      end
      S_DOT_SET: begin
        case (cv_r)
          2'd0: begin
            ax = pix_r; ay = piy_r; bx = pkx_r; by = pky_r; cxp = pjx_r; cyp = pjy_r;
          end
          2'd1: begin
            ax = pkx_r; ay = pky_r; bx = pjx_r; by = pjy_r; cxp = pix_r; cyp = piy_r;
          end
          default: begin
            ax = pjx_r; ay = pjy_r; bx = pix_r; by = piy_r; cxp = pkx_r; cyp = pky_r;
          end
        endcase
        ux_nxt    = DW'(bx) - DW'(ax);
        uy_nxt    = DW'(by) - DW'(ay);
        vx_nxt    = DW'(cxp) - DW'(ax);
        vy_nxt    = DW'(cyp) - DW'(ay);
        dot_nxt   = 1'b1;
        phase_nxt = PH_DOT;
      end
      S_CINIT: begin
        // left half plane: pre-rotate by -90 degrees
        if (acc_r < 0) begin
          cx_nxt = KW'(area_r);
          cy_nxt = -KW'(acc_r);
          cz_nxt = $signed(ZW'(HALF_PI_Q30));
        end else begin
          cx_nxt = KW'(acc_r);
          cy_nxt = KW'(area_r);
          cz_nxt = '0;
        end
        s_nxt = '0;
      end
      S_CITER: begin
        if (!cy_r[KW-1]) begin
          cx_nxt = cx_r + (cy_r >>> s_r);
          cy_nxt = cy_r - (cx_r >>> s_r);
          cz_nxt = cz_r + $signed(ZW'(atan_q30(s_r)));
        end else begin
          cx_nxt = cx_r - (cy_r >>> s_r);
          cy_nxt = cy_r + (cx_r >>> s_r);
          cz_nxt = cz_r - $signed(ZW'(atan_q30(s_r)));
        end
        s_nxt = s_r + 1'b1;
      end
      S_CDONE: begin
        if (ang > m_r) m_nxt = ang;
        cv_nxt = cv_r + 1'b1;
        o_nxt  = '0;
      end
      S_OFETCH: begin
        pt_addr = o_r[IW-1:0];
        if (o_r == n_r) tri_nxt = m_r;
        else if (o_r == i_r || o_r == j_r || o_r == k_r) o_nxt = o_r + 1'b1;
      end
      S_OWAIT: begin
        pox_nxt = pt_rdx_r;
        poy_nxt = pt_rdy_r;
        ci_nxt  = '0;
      end
      S_IN_SET: begin
        case (ci_r)
          2'd0: begin
            ax = pix_r; ay = piy_r; bx = pkx_r; by = pky_r;
          end
          2'd1: begin
            ax = pkx_r; ay = pky_r; bx = pjx_r; by = pjy_r;
          end
          default: begin
            ax = pjx_r; ay = pjy_r; bx = pix_r; by = piy_r;
          end
        endcase
        ux_nxt    = DW'(bx) - DW'(ax);
        uy_nxt    = DW'(by) - DW'(ay);
        vx_nxt    = DW'(pox_r) - DW'(ax);
        vy_nxt    = DW'(poy_r) - DW'(ay);
        dot_nxt   = 1'b0;
        phase_nxt = PH_IN;
      end
      S_SUM: begin
        if (k_r == i_r + 1'b1 || val < best_r) begin
          best_nxt = val;
          bk_nxt   = k_r;
        end
        k_nxt = k_r + 1'b1;
      end
      S_WRITE: begin
        tab_we = 1'b1;
        if ((size_r + 1'b1) == n_r) begin
          stat_nxt = (best_r >= PENALTY) ? STAT_PEN : STAT_OK;
        end else if ((j_r + 1'b1) < n_r) begin
          i_nxt = i_r + 1'b1;
          j_nxt = j_r + 1'b1;
        end else begin
          size_nxt = size_r + 1'b1;
          i_nxt    = '0;
          j_nxt    = size_r + 1'b1;
        end
      end
      S_BINIT: begin
        head_nxt = '0;
        tail_nxt = CW'(1);
        res_nxt  = '0;
        q_we     = 1'b1;
        q_waddr  = '0;
        q_wdata  = {IW'(0), IW'(n_r - 1'b1)};
      end
      S_QRD: ;
      S_QWAIT: begin
        qi_nxt    = CW'(q_rd_r[2*IW-1:IW]);
        qj_nxt    = CW'(q_rd_r[IW-1:0]);
        tab_raddr = q_rd_r;
        head_nxt  = head_r + 1'b1;
      end
      S_SWAIT: begin
        qk_nxt  = CW'(split_rd_r);
        ov_nxt  = 1'b1;
        od_nxt  = '{corner_first: 5'(qi_r), corner_apex: 5'(split_rd_r),
                    corner_second: 5'(qj_r),
                    last_triangle: (last_cmp == ({1'b0, n_r} - (CW + 1)'(2))),
                    status: stat_r};
        res_nxt = res_r + 1'b1;
      end
      S_PUSH1: begin
        if (({1'b0, qk_r} + (CW + 1)'(2)) <= {1'b0, qj_r} && tail_r < MAXC) begin
          q_we     = 1'b1;
          q_wdata  = {qk_r[IW-1:0], qj_r[IW-1:0]};
          tail_nxt = tail_r + 1'b1;
        end
      end
      S_PUSH2: begin
        if (({1'b0, qi_r} + (CW + 1)'(2)) <= {1'b0, qk_r} && tail_r < MAXC) begin
          q_we     = 1'b1;
          q_wdata  = {qi_r[IW-1:0], qk_r[IW-1:0]};
          tail_nxt = tail_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;  size_r <= size_nxt;
    i_r <= i_nxt;  j_r <= j_nxt;  k_r <= k_nxt;  o_r <= o_nxt;
    head_r <= head_nxt;  tail_r <= tail_nxt;  res_r <= res_nxt;
    qi_r <= qi_nxt;  qj_r <= qj_nxt;  qk_r <= qk_nxt;  bk_r <= bk_nxt;
    pix_r <= pix_nxt;  piy_r <= piy_nxt;  pjx_r <= pjx_nxt;  pjy_r <= pjy_nxt;
    pkx_r <= pkx_nxt;  pky_r <= pky_nxt;  pox_r <= pox_nxt;  poy_r <= poy_nxt;
    cik_r <= cik_nxt;  ckj_r <= ckj_nxt;  best_r <= best_nxt;  tri_r <= tri_nxt;
    m_r <= m_nxt;  area_r <= area_nxt;  acc_r <= acc_nxt;
    ux_r <= ux_nxt;  uy_r <= uy_nxt;  vx_r <= vx_nxt;  vy_r <= vy_nxt;
    dot_r <= dot_nxt;  phase_r <= phase_nxt;  cv_r <= cv_nxt;  ci_r <= ci_nxt;
    cx_r <= cx_nxt;  cy_r <= cy_nxt;  cz_r <= cz_nxt;  s_r <= s_nxt;
    stat_r <= stat_nxt;  od_r <= od_nxt;
  end

endmodule
`default_nettype wire

// ===== test/min_max_angle_polygon_triangulation_checker.sv =====
module min_max_angle_polygon_triangulation_checker (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic           busy,
  input  wire mmat_pkg::in_t  in_data,
  input  wire logic           out_valid,
  input  wire mmat_pkg::out_t out_data,
  output int                  errors,
  output int                  pending
);
  import mmat_pkg::*;

  localparam int         NPTS     = 32;
  localparam longint     HALF_PI  = 64'd1686629713;
  localparam longint     PEN_COST = 64'd1024 << 16;
  localparam longint     SAT_COST = 64'hFFFF_FFFF;

  longint   vx [NPTS];
  longint   vy [NPTS];
  longint   span_cost [NPTS][NPTS];
  bit [4:0] span_apex [NPTS][NPTS];
  int       vert_count;
  bit       dropped;
  out_t     tri_expect [$];

  task automatic expect_tri(input out_t t);
    tri_expect = {tri_expect, t};
  endtask

  function automatic longint atan_step(input int s);
    case (s)
      0: return 843314857;
      1: return 497837829;
      2: return 263043837;
      3: return 133525159;
      4: return 67021687;
      5: return 33543516;
      6: return 16775851;
      7: return 8388437;
      8: return 4194283;
      9: return 2097149;
      default: return longint'(1) << (30 - s);
    endcase
  endfunction

  // vectoring cordic, result in unsigned q.16 radians
  function automatic longint vec_angle(input longint yv, input longint xv);
    longint x, y, z, dx, dy, t;
    x = xv;
    y = yv;
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = HALF_PI;
    end
    for (int s = 0; s < 31; s++) begin
      dx = y >>> s;
      dy = x >>> s;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(s);
      end else begin
        x -= dx; y += dy; z -= atan_step(s);
      end
    end
    if (z < 0) z = 0;
    return (z + (longint'(1) << 13)) >> 14;
  endfunction

  function automatic longint orient(input int a, input int b, input longint px, input longint py);
    return (vx[b] - vx[a]) * (py - vy[a]) - (vy[b] - vy[a]) * (px - vx[a]);
  endfunction

  function automatic longint tri_angle_cost(input int i, input int k, input int j, input int n);
    int     c [3];
    int     a, p, q;
    longint area, d, ang, worst;
    c[0] = i; c[1] = k; c[2] = j;
    worst = 0;
    area = orient(i, k, vx[j], vy[j]);
    if (area <= 0) return PEN_COST;
    for (int v = 0; v < 3; v++) begin
      a = c[v]; p = c[(v + 1) % 3]; q = c[(v + 2) % 3];
      d = (vx[p] - vx[a]) * (vx[q] - vx[a]) + (vy[p] - vy[a]) * (vy[q] - vy[a]);
      ang = vec_angle(area, d);
      if (ang > worst) worst = ang;
    end
    for (int o = 0; o < n; o++) begin
      if (o != i && o != j && o != k && orient(i, k, vx[o], vy[o]) > 0 &&
          orient(k, j, vx[o], vy[o]) > 0 && orient(j, i, vx[o], vy[o]) > 0)
        return PEN_COST;
    end
    return worst;
  endfunction

  function automatic out_t make_tri(input int i, input int k, input int j, input bit lst,
                                    input logic [1:0] st);
    out_t r;
    r.corner_first  = i[4:0];
    r.corner_apex   = k[4:0];
    r.corner_second = j[4:0];
    r.last_triangle = lst;
    r.status        = st;
    return r;
  endfunction

  task automatic triangulate(input int n);
    longint     best, val;
    int         bk, head, cnt, i, j, k;
    int         lo_q [NPTS];
    int         hi_q [NPTS];
    int         tail;
    logic [1:0] st;
    for (int sz = 2; sz < n; sz++) begin
      for (i = 0; i + sz < n; i++) begin
        j = i + sz;
        best = 0;
        bk = i + 1;
        for (k = i + 1; k < j; k++) begin
          val = span_cost[i][k] + span_cost[k][j] + tri_angle_cost(i, k, j, n);
          if (val > SAT_COST) val = SAT_COST;
          if (k == i + 1 || val < best) begin
            best = val;
            bk = k;
          end
        end
        span_cost[i][j] = best;
        span_apex[i][j] = bk[4:0];
      end
    end
    st = (span_cost[0][n-1] >= PEN_COST) ? STAT_PEN : STAT_OK;
    head = 0; tail = 1; cnt = 0;
    lo_q[0] = 0; hi_q[0] = n - 1;
    // breadth-first walk over the chosen splits
    while (head < tail) begin
      i = lo_q[head];
      j = hi_q[head];
      head++;
      k = span_apex[i][j];
      expect_tri(make_tri(i, k, j, cnt + 1 == n - 2, st));
      cnt++;
      if (k + 2 <= j && tail < NPTS) begin
        lo_q[tail] = k; hi_q[tail] = j; tail++;
      end
      if (i + 2 <= k && tail < NPTS) begin
        lo_q[tail] = i; hi_q[tail] = k; tail++;
      end
    end
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    vert_count = 0;
    dropped = 0;
    for (int a = 0; a < NPTS; a++)
      for (int b = 0; b < NPTS; b++) span_cost[a][b] = 0;
  end

  always @(posedge clk) begin
    out_t w;
    int   n;
    if (!rst_n) begin
      vert_count = 0;
      dropped = 0;
    end else begin
      if (out_valid) begin
        if (tri_expect.size() == 0) begin
          report("unexpected transaction, first corner", out_data.corner_first, -1);
        end else begin
          w = tri_expect.pop_front();
          if (out_data.corner_first !== w.corner_first)
            report("corner_first", out_data.corner_first, w.corner_first);
          if (out_data.corner_apex !== w.corner_apex)
            report("corner_apex", out_data.corner_apex, w.corner_apex);
          if (out_data.corner_second !== w.corner_second)
            report("corner_second", out_data.corner_second, w.corner_second);
          if (out_data.last_triangle !== w.last_triangle)
            report("last_triangle", out_data.last_triangle, w.last_triangle);
          if (out_data.status !== w.status)
            report("status", out_data.status, w.status);
        end
      end
      if (start && !busy) begin
        n = vert_count;
        if (n < NPTS) begin
          vx[n] = longint'(in_data.x_coord);
          vy[n] = longint'(in_data.y_coord);
          n++;
        end else begin
          dropped = 1;
        end
        if (in_data.last_point) begin
          if (dropped) expect_tri(make_tri(0, 0, 0, 1, STAT_MANY));
          else if (n < 3) expect_tri(make_tri(0, 0, 0, 1, STAT_FEW));
          else triangulate(n);
          n = 0;
          dropped = 0;
        end
        vert_count = n;
      end
    end
    pending = tri_expect.size();
  end

endmodule

// ===== test/min_max_angle_polygon_triangulation_tb.sv =====
module min_max_angle_polygon_triangulation_tb;
  import mmat_pkg::*;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;
  int   errors;
  int   pending;
  int   items;
  bit   no_gaps;
  int   shape_x [$];
  int   shape_y [$];

  min_max_angle_polygon_triangulation u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data)
  );

  min_max_angle_polygon_triangulation_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int cos16(input int k);
    case (k % 16)
      0: return 1000;   1: return 924;    2: return 707;    3: return 383;
      4: return 0;      5: return -383;   6: return -707;   7: return -924;
      8: return -1000;  9: return -924;  10: return -707;  11: return -383;
      12: return 0;    13: return 383;   14: return 707;   15: return 924;
      default: return 0;
    endcase
  endfunction

  task automatic send_vertex(input int x, input int y, input bit lst);
    start <= 1'b1;
    in_data <= '{x_coord: x[15:0], y_coord: y[15:0], last_point: lst};
    do @(posedge clk); while (busy);
    items++;
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_shape();
    for (int v = 0; v < shape_x.size(); v++)
      send_vertex(shape_x[v], shape_y[v], v == shape_x.size() - 1);
    shape_x.delete();
    shape_y.delete();
  endtask

  task automatic add_pt(input int x, input int y);
    shape_x = {shape_x, x};
    shape_y = {shape_y, y};
  endtask

  // convex polygon on a scaled circle, optional jitter and reversed winding
  task automatic make_convex(input int n);
    int r, cx, cy, off, need, x, y, jit;
    bit rev;
    r = $urandom_range(1, 30);
    cx = $urandom_range(0, 4000) - 2000;
    cy = $urandom_range(0, 4000) - 2000;
    off = $urandom_range(0, 15);
    jit = ($urandom_range(0, 3) == 0) ? 300 : 0;
    rev = ($urandom_range(0, 9) == 0);
    need = n;
    for (int idx = 0; idx < 16; idx++) begin
      if ($urandom_range(0, 15 - idx) < need) begin
        need--;
        x = cx + r * cos16(off + idx) + $urandom_range(0, jit) - jit / 2;
        y = cy + r * cos16(off + idx + 12) + $urandom_range(0, jit) - jit / 2;
        if (rev) begin
          shape_x.push_front(x); shape_y.push_front(y);
        end else add_pt(x, y);
      end
    end
  endtask

  initial begin
    int sel, n;
    bit overflow_done;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    items = 0;
    no_gaps = 0;
    overflow_done = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // polygons of one and two vertices give the error transaction; then a counter-clockwise triangle
    add_pt(-32768, -32768); send_shape();
    add_pt(32767, 32767); add_pt(0, 0); send_shape();
    add_pt(0, 0); add_pt(100, 0); add_pt(0, 100); send_shape();
    // clockwise and collinear both hit the penalty; then a full-range square
    add_pt(0, 0); add_pt(0, 100); add_pt(100, 0); send_shape();
    add_pt(0, 0); add_pt(10, 10); add_pt(20, 20); send_shape();
    add_pt(-32768, -32768); add_pt(32767, -32768); add_pt(32767, 32767);
    add_pt(-32768, 32767); send_shape();
    // concave: the notch vertex falls inside some candidate triangles
    add_pt(0, 0); add_pt(200, 0); add_pt(100, 50); add_pt(200, 200); add_pt(0, 200);
    send_shape();

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);

    while (items < 290) begin
      sel = $urandom_range(0, 99);
      no_gaps = ($urandom_range(0, 4) == 0);
      if (!overflow_done && items > 140) begin
        overflow_done = 1;
        for (int v = 0; v < 33; v++) add_pt($urandom_range(0, 65535), $urandom_range(0, 65535));
        send_shape();
      end else if (sel < 75) begin
        make_convex($urandom_range(3, 8));
        send_shape();
      end else if (sel < 90) begin
        n = $urandom_range(3, 6);
        for (int v = 0; v < n; v++) add_pt($urandom_range(0, 65535), $urandom_range(0, 65535));
        send_shape();
      end else if (sel < 95) begin
        n = $urandom_range(1, 2);
        for (int v = 0; v < n; v++) add_pt($urandom_range(0, 65535), $urandom_range(0, 65535));
        send_shape();
      end else begin
        make_convex($urandom_range(9, 12));
        send_shape();
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
